### hw/rtl/sppf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppf_pkg: shared types and constants of the set-packing fitness scorer
// Widths of item fields, score unit request/response, state encodings.
// ----------------------------------------------------------------------------
package sppf_pkg;

  // default number of item slots
  parameter int NUM_ITEMS_DEF = 1024;

  // field widths
  parameter int WEIGHT_W = 32;
  parameter int IDX_W    = 11;
  parameter int TW_W     = 40;
  parameter int SUM_W    = 48;
  parameter int MAG_W    = 18;
  parameter int SCORE_W  = 64;
  parameter int CNT_W    = 8;
  parameter int CFG_IDX_W  = 8;
  parameter int CFG_DATA_W = 40;

  // configuration register indexes
  parameter logic [CFG_IDX_W-1:0] REG_TOTAL_WEIGHT = 8'd0;
  parameter logic [CFG_IDX_W-1:0] REG_ITEM_RANGE   = 8'd1;

  parameter logic [TW_W-1:0]  TOTAL_WEIGHT_RST = 40'd1;
  parameter logic [IDX_W-1:0] ITEM_RANGE_RST   = 11'd1024;
  parameter logic [CNT_W-1:0] COUNT_MAX        = 8'd255;

  // score unit sizes: F*F is 96 bits, times ten is 100 bits
  parameter int PROD_W = 96;
  parameter int DIVN_W = 100;
  parameter int STEP_W = 7;
  parameter logic [STEP_W-1:0] MUL_LAST = 7'd47;
  parameter logic [STEP_W-1:0] DIV_LAST = 7'd99;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_UPD, ST_WALK, ST_WSUM, ST_STRT, ST_SCORE, ST_OUT
  } sppf_state_e;

  typedef enum logic [2:0] {
    SU_IDLE, SU_SQ, SU_X10, SU_DIV, SU_MAG, SU_FIN
  } sppf_su_state_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] fit;
    logic [MAG_W-1:0] mag;
    logic [TW_W-1:0]  divisor;
  } sppf_req_t;

  typedef struct packed {
    logic               done;
    logic [SCORE_W-1:0] score;
  } sppf_rsp_t;

endpackage

### hw/rtl/sppf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppf_in_if / sppf_out_if: valid/ready channels of the fitness scorer
// One entry per input item, one score per output item.
// ----------------------------------------------------------------------------
interface sppf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          bid_selected;
  logic [sppf_pkg::WEIGHT_W-1:0] bid_weight;
  logic                          has_item;
  logic [sppf_pkg::IDX_W-1:0]    item_index;
  logic                          bid_end;
  logic                          chrom_end;

  modport source(output valid, bid_selected, bid_weight, has_item, item_index,
                 bid_end, chrom_end, input ready);
  modport sink(input valid, bid_selected, bid_weight, has_item, item_index,
               bid_end, chrom_end, output ready);
endinterface

interface sppf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sppf_pkg::SCORE_W-1:0] score;
  logic                                feasible;
  logic [sppf_pkg::MAG_W-1:0]          clash_magnitude;

  modport source(output valid, score, feasible, clash_magnitude, input ready);
  modport sink(input valid, score, feasible, clash_magnitude, output ready);
endinterface

### hw/rtl/sppf_score_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppf_score_unit: serial penalty arithmetic
// score = F - F*M - floor(10*F*F / W), saturated to -2^63, using one
// shift-add multiplier and one restoring divider step per cycle.
// ----------------------------------------------------------------------------
module sppf_score_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sppf_pkg::sppf_req_t req_i,
  output sppf_pkg::sppf_rsp_t rsp_o
);

  sppf_pkg::sppf_su_state_e state_q, state_d;

  logic [sppf_pkg::SUM_W-1:0]   f_q;
  logic [sppf_pkg::MAG_W-1:0]   m_q;
  logic [sppf_pkg::TW_W-1:0]    w_q;
  logic [sppf_pkg::PROD_W-1:0]  mcand_q, acc_q;
  logic [sppf_pkg::SUM_W-1:0]   mplier_q;
  logic [sppf_pkg::DIVN_W-1:0]  n_q, q_q;
  logic [sppf_pkg::TW_W-1:0]    rem_q;
  logic [sppf_pkg::STEP_W-1:0]  cnt_q;
  logic [sppf_pkg::SCORE_W-1:0] score_q;
  logic                         done_q;
  logic                         fin;

  // datapath helpers
  logic [sppf_pkg::PROD_W-1:0]  acc_add;
  logic [sppf_pkg::TW_W:0]      rem_sh;
  logic                         rem_ge;
  logic [sppf_pkg::SCORE_W-1:0] a_lo, q_lo, cap;
  logic [sppf_pkg::SCORE_W-1:0] tot;
  logic                         sat;

  assign acc_add = mplier_q[0] ? acc_q + mcand_q : acc_q;
  assign rem_sh  = {rem_q, n_q[sppf_pkg::DIVN_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, w_q};

  assign a_lo = acc_q[sppf_pkg::SCORE_W-1:0];
  assign q_lo = q_q[sppf_pkg::SCORE_W-1:0];
  assign cap  = sppf_pkg::SCORE_W'(f_q) + {1'b1, {(sppf_pkg::SCORE_W-1){1'b0}}};
  // 64-bit sum, wraps like the word it models
  assign tot  = a_lo + q_lo;
  assign sat  = (|q_q[sppf_pkg::DIVN_W-1:sppf_pkg::SCORE_W]) ||
                (|acc_q[sppf_pkg::PROD_W-1:sppf_pkg::SCORE_W]) ||
                (q_lo > cap) || (a_lo > cap) || (tot > cap);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sppf_pkg::SU_IDLE: if (req_i.start) state_d = sppf_pkg::SU_SQ;
      sppf_pkg::SU_SQ:   if (cnt_q == sppf_pkg::MUL_LAST) state_d = sppf_pkg::SU_X10;
      sppf_pkg::SU_X10:  state_d = sppf_pkg::SU_DIV;
      sppf_pkg::SU_DIV:  if (cnt_q == sppf_pkg::DIV_LAST) state_d = sppf_pkg::SU_MAG;
      sppf_pkg::SU_MAG:  if (cnt_q == sppf_pkg::MUL_LAST) state_d = sppf_pkg::SU_FIN;
      sppf_pkg::SU_FIN:  state_d = sppf_pkg::SU_IDLE;
      default:           state_d = sppf_pkg::SU_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    fin = 1'b0;
    case (state_q)
      sppf_pkg::SU_FIN: fin = 1'b1;
      default:          fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sppf_pkg::SU_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      sppf_pkg::SU_IDLE: begin
        f_q      <= req_i.fit;
        m_q      <= req_i.mag;
        w_q      <= (req_i.divisor == '0) ? sppf_pkg::TW_W'(1) : req_i.divisor;
        acc_q    <= '0;
        mcand_q  <= sppf_pkg::PROD_W'(req_i.fit);
        mplier_q <= req_i.fit;
        cnt_q    <= '0;
      end
      sppf_pkg::SU_SQ, sppf_pkg::SU_MAG: begin
        acc_q    <= acc_add;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q + 1'b1;
      end
      sppf_pkg::SU_X10: begin
        // times ten as 8x + 2x
        n_q   <= (sppf_pkg::DIVN_W'(acc_q) << 3) + (sppf_pkg::DIVN_W'(acc_q) << 1);
        q_q   <= '0;
        rem_q <= '0;
        cnt_q <= '0;
      end
      sppf_pkg::SU_DIV: begin
        rem_q <= rem_ge ? sppf_pkg::TW_W'(rem_sh - {1'b0, w_q})
                        : rem_sh[sppf_pkg::TW_W-1:0];
        q_q   <= {q_q[sppf_pkg::DIVN_W-2:0], rem_ge};
        n_q   <= n_q << 1;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == sppf_pkg::DIV_LAST) begin
          // reload the multiplier for F*M
          acc_q    <= '0;
          mcand_q  <= sppf_pkg::PROD_W'(f_q);
          mplier_q <= sppf_pkg::SUM_W'(m_q);
          cnt_q    <= '0;
        end
      end
      sppf_pkg::SU_FIN: begin
        score_q <= sat ? {1'b1, {(sppf_pkg::SCORE_W-1){1'b0}}}
                       : sppf_pkg::SCORE_W'(f_q) - tot;
      end
      default: ;
    endcase
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.score = score_q;

endmodule

### hw/rtl/set_packing_penalty_fitness_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_packing_penalty_fitness_core: set-packing penalty fitness scorer
// Counts item claims of selected bids, sums bid weights until the first
// clash and scores a clashing chromosome with a serial penalty unit.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                           Accept
// in_i     in   bid_selected bid_weight has_item item_index       valid&ready
//               bid_end chrom_end
// out_o    out  score feasible clash_magnitude                    valid&ready
// cfg      in   cfg_we_i cfg_idx_i cfg_data_i                     cfg_we_i
//
// An entry is a count read, then a count write-back before the next is taken.
// A chromosome end adds a count walk that also clears the counts, and, when
// a clash was seen, a run of the serial multiply/divide unit.
// After reset a clearing pass over all NUM_ITEMS slots runs first.
// A result waits in the output register; the next entries are taken meanwhile.
// ----------------------------------------------------------------------------
module set_packing_penalty_fitness_core #(
  parameter int NUM_ITEMS = sppf_pkg::NUM_ITEMS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sppf_in_if.sink                          in_i,
  sppf_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [sppf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sppf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int AW   = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam int CMPW = (AW + 1 > sppf_pkg::IDX_W + 1) ? AW + 1 : sppf_pkg::IDX_W + 1;
  localparam logic [AW-1:0]   LAST_K  = AW'(NUM_ITEMS - 1);
  localparam logic [CMPW-1:0] N_ITEMS = CMPW'(NUM_ITEMS);

  sppf_pkg::sppf_state_e state_q, state_d;

  // configuration
  logic [sppf_pkg::TW_W-1:0]  total_weight_q;
  logic [sppf_pkg::IDX_W-1:0] item_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_weight_q <= sppf_pkg::TOTAL_WEIGHT_RST;
      item_range_q   <= sppf_pkg::ITEM_RANGE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sppf_pkg::REG_TOTAL_WEIGHT)
        total_weight_q <= cfg_data_i[sppf_pkg::TW_W-1:0];
      else if (cfg_idx_i == sppf_pkg::REG_ITEM_RANGE)
        item_range_q <= cfg_data_i[sppf_pkg::IDX_W-1:0];
    end
  end

  // input decode
  logic            in_acc;
  logic [CMPW-1:0] idx_ext;
  logic            idx_ok;
  logic [AW-1:0]   in_addr;

  assign in_acc  = in_i.valid && in_i.ready;
  assign idx_ext = CMPW'(in_i.item_index);
  assign idx_ok  = (idx_ext != '0) && (idx_ext <= N_ITEMS);
  assign in_addr = AW'(idx_ext - CMPW'(1));

  // latched entry
  logic                          ent_cnt_q, ent_bsel_q, ent_cend_q;
  logic [sppf_pkg::WEIGHT_W-1:0] ent_wt_q;
  logic [AW-1:0]                 ent_addr_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ent_cnt_q  <= in_i.bid_selected && in_i.has_item && idx_ok;
      ent_bsel_q <= in_i.bid_selected && in_i.bid_end;
      ent_cend_q <= in_i.chrom_end;
      ent_wt_q   <= in_i.bid_weight;
      ent_addr_q <= in_addr;
    end
  end

  // count RAM
  logic [sppf_pkg::CNT_W-1:0] mem [NUM_ITEMS];
  logic [sppf_pkg::CNT_W-1:0] rd_q, mem_wd;
  logic                       mem_we;
  logic [AW-1:0]              mem_wa, mem_ra;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  // walk counter and score unit link
  logic [AW-1:0]       k_q;
  logic                k_last;
  logic                walk_v_q, walk_inr_q;
  sppf_pkg::sppf_req_t su_req;
  sppf_pkg::sppf_rsp_t su_rsp;
  logic                in_ready, do_out, do_walk;

  // accumulators
  logic                       no_clash_q, no_clash_now;
  logic [sppf_pkg::SUM_W-1:0] sum_q;
  logic [sppf_pkg::SUM_W:0]   sum_add;
  logic [sppf_pkg::MAG_W-1:0] mag_q;
  logic [sppf_pkg::MAG_W:0]   mag_add;

  // output register
  logic                         out_valid_q;
  logic [sppf_pkg::SCORE_W-1:0] out_score_q;
  logic                         out_feas_q;
  logic [sppf_pkg::MAG_W-1:0]   out_mag_q;

  assign k_last = (k_q == LAST_K);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sppf_pkg::ST_CLR:   if (k_last) state_d = sppf_pkg::ST_IDLE;
      sppf_pkg::ST_IDLE:  if (in_acc) state_d = sppf_pkg::ST_UPD;
      sppf_pkg::ST_UPD:   state_d = ent_cend_q ? sppf_pkg::ST_WALK : sppf_pkg::ST_IDLE;
      sppf_pkg::ST_WALK:  if (k_last) state_d = sppf_pkg::ST_WSUM;
      sppf_pkg::ST_WSUM:  state_d = no_clash_q ? sppf_pkg::ST_OUT : sppf_pkg::ST_STRT;
      sppf_pkg::ST_STRT:  state_d = sppf_pkg::ST_SCORE;
      sppf_pkg::ST_SCORE: if (su_rsp.done) state_d = sppf_pkg::ST_OUT;
      sppf_pkg::ST_OUT:   if (!out_valid_q || out_o.ready) state_d = sppf_pkg::ST_IDLE;
      default:            state_d = sppf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready     = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = k_q;
    mem_wd       = '0;
    mem_ra       = k_q;
    do_out       = 1'b0;
    do_walk      = 1'b0;
    su_req.start = 1'b0;
    case (state_q)
      sppf_pkg::ST_CLR: begin
        mem_we  = 1'b1;
        do_walk = 1'b1;
      end
      sppf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        mem_ra   = in_addr;
      end
      sppf_pkg::ST_UPD: begin
        mem_we = ent_cnt_q;
        mem_wa = ent_addr_q;
        mem_wd = (rd_q == sppf_pkg::COUNT_MAX) ? rd_q : rd_q + 1'b1;
      end
      sppf_pkg::ST_WALK: begin
        mem_we  = 1'b1;
        do_walk = 1'b1;
      end
      sppf_pkg::ST_STRT:  su_req.start = 1'b1;
      sppf_pkg::ST_OUT:   do_out = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;

  assign no_clash_now = no_clash_q && !(ent_cnt_q && (rd_q != '0));
  assign sum_add      = {1'b0, sum_q} + (sppf_pkg::SUM_W + 1)'(ent_wt_q);
  assign mag_add      = {1'b0, mag_q} + (sppf_pkg::MAG_W + 1)'(rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sppf_pkg::ST_CLR;
      k_q        <= '0;
      walk_v_q   <= 1'b0;
      walk_inr_q <= 1'b0;
      no_clash_q <= 1'b1;
      sum_q      <= '0;
      mag_q      <= '0;
    end else begin
      state_q    <= state_d;
      walk_v_q   <= (state_q == sppf_pkg::ST_WALK);
      walk_inr_q <= CMPW'(k_q) < CMPW'(item_range_q);
      if (do_walk) k_q <= k_last ? '0 : k_q + 1'b1;
      // claim first, then weight on bid end
      if (state_q == sppf_pkg::ST_UPD) begin
        no_clash_q <= no_clash_now;
        if (ent_bsel_q && no_clash_now)
          sum_q <= sum_add[sppf_pkg::SUM_W] ? '1 : sum_add[sppf_pkg::SUM_W-1:0];
      end
      // clash magnitude over slots in range with count of two or more
      if (walk_v_q && walk_inr_q && (rd_q >= sppf_pkg::CNT_W'(2)))
        mag_q <= mag_add[sppf_pkg::MAG_W] ? '1 : mag_add[sppf_pkg::MAG_W-1:0];
      if (do_out) begin
        no_clash_q <= 1'b1;
        sum_q      <= '0;
        mag_q      <= '0;
      end
    end
  end

  // penalty unit
  assign su_req.fit     = sum_q;
  assign su_req.mag     = mag_q;
  assign su_req.divisor = total_weight_q;

  sppf_score_unit u_score (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (su_req),
    .rsp_o  (su_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_out) begin
      out_score_q <= no_clash_q ? sppf_pkg::SCORE_W'(sum_q) : su_rsp.score;
      out_feas_q  <= no_clash_q;
      out_mag_q   <= mag_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.score           = out_score_q;
  assign out_o.feasible        = out_feas_q;
  assign out_o.clash_magnitude = out_mag_q;

endmodule
